/* design/htpi_pkg.sv */
`default_nettype none

package htpi_pkg;

	// Defaults for the top-level parameters.
	localparam int TABLE_SLOTS_DEF  = 256;
	localparam int PROBE_STRIDE_DEF = 7;

	// Field widths of the stream items.
	localparam int KEY_W     = 24;
	localparam int PAYLOAD_W = 32;
	localparam int SLOT_W    = 8;
	localparam int COUNT_W   = 32;
	localparam int DIGIT_W   = 4;

	// Home slot digit sum: (d1+d2)*100 + (d3+d4)*10 + d5+d6, at most 3330.
	localparam int SUM_MAX = 3330;
	localparam int SUM_W   = 12;
	localparam int MUL_HUNDREDS = 100;
	localparam int MUL_TENS     = 10;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE
	} back_state_t;

	// One table entry as held in the slot memory.
	typedef struct packed {
		logic                 occ;
		logic [KEY_W-1:0]     key;
		logic [PAYLOAD_W-1:0] payload;
	} entry_t;

endpackage

`default_nettype wire

/* design/hash_table_probe_insert.sv */
`default_nettype none

// Channel    Dir  Handshake          Payload
// s_*        in   s_tvalid/s_tready  s_tdata: key_bcd[23:0], payload[55:24]
// m_*        out  m_tvalid/m_tready  m_tdata: slot_used[7:0], evicted_key[31:8],
//                                    collision_count[63:32]; m_tuser: evicted
//
// After reset the slot memory is cleared one slot a cycle, and s_tready stays
// low until that pass is done. The front takes an input transaction, reduces
// the key's digit sum by the table size in its divide state (a multiply by a
// scaled reciprocal and one subtract) and hands the item to a two-entry queue;
// it takes no new transaction until that item is pushed. The back reads
// one slot per cycle from the slot memory: an insert whose home slot is free
// finishes after the home read, each further probe step reads one more slot,
// and on a full table the walk goes round the table before the home entry
// is evicted. The probe walk is what sets the rate. A finished
// result sits in an output register; the back only stalls when that register
// is still full at the moment it completes the next insert, and the front keeps
// accepting until the queue fills.

module hash_table_probe_insert
	import htpi_pkg::*;
#(
	parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
	parameter int PROBE_STRIDE = PROBE_STRIDE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // key_bcd[23:0], payload[55:24]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // slot_used[7:0], evicted_key[31:8], collision_count[63:32]
	output logic [0:0]       m_tuser    // evicted[0]
);

	localparam int SW     = $clog2(TABLE_SLOTS);
	localparam int ITEM_W = KEY_W + PAYLOAD_W + SW;

	// Front to queue.
	logic                 f_push;
	logic [KEY_W-1:0]     f_key;
	logic [PAYLOAD_W-1:0] f_payload;
	logic [SW-1:0]        f_home;

	// Queue to back.
	logic              q_full, q_valid, q_pop;
	logic [ITEM_W-1:0] q_data;

	logic clearing;

	logic [SLOT_W-1:0]  r_slot;
	logic               r_evicted;
	logic [KEY_W-1:0]   r_evicted_key;
	logic [COUNT_W-1:0] r_count;

	// The front classifies each item by its home slot.
	htpi_front #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (clearing),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_key     (s_tdata[23:0]),
		.in_payload (s_tdata[55:24]),
		.q_full     (q_full),
		.push       (f_push),
		.key        (f_key),
		.payload    (f_payload),
		.home       (f_home)
	);

	// The queue lets the front run ahead while the back walks the table.
	htpi_queue #(
		.DATA_W (ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_home, f_payload, f_key}),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	// The back owns the slot memory, the probe walk and the collision count.
	htpi_back #(
		.TABLE_SLOTS  (TABLE_SLOTS),
		.PROBE_STRIDE (PROBE_STRIDE)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.clearing        (clearing),
		.q_valid         (q_valid),
		.pop             (q_pop),
		.q_key           (q_data[KEY_W-1:0]),
		.q_payload       (q_data[KEY_W+PAYLOAD_W-1:KEY_W]),
		.q_home          (q_data[ITEM_W-1:KEY_W+PAYLOAD_W]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_slot        (r_slot),
		.out_evicted     (r_evicted),
		.out_evicted_key (r_evicted_key),
		.out_count       (r_count)
	);

	assign m_tdata = {r_count, r_evicted_key, r_slot};
	assign m_tuser = r_evicted;

endmodule

`default_nettype wire

/* design/htpi_front.sv */
`default_nettype none

module htpi_front
	import htpi_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           hold,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [KEY_W-1:0]               in_key,
	input  wire logic [PAYLOAD_W-1:0]           in_payload,
	input  wire logic                           q_full,
	output logic                                push,
	output logic [KEY_W-1:0]                    key,
	output logic [PAYLOAD_W-1:0]                payload,
	output logic [$clog2(TABLE_SLOTS)-1:0]      home
);

	localparam int SW          = $clog2(TABLE_SLOTS);
	// Scaled reciprocal of the table size, exact for every SUM_W-bit digit sum.
	localparam int RECIP_SHIFT = SUM_W + $clog2(TABLE_SLOTS);
	localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + TABLE_SLOTS - 1) / TABLE_SLOTS;
	localparam int PROD_W      = 2 * SUM_W + 2;

	front_state_t state_q, state_d;
	logic [SUM_W-1:0]     sum;
	logic [SUM_W-1:0]     rem_q;
	logic [PROD_W-1:0]    prod;
	logic [SUM_W-1:0]     quo;
	logic [SUM_W-1:0]     reduced;
	logic [KEY_W-1:0]     key_q;
	logic [PAYLOAD_W-1:0] payload_q;

	// Digit sum of the key, first digit in the top nibble.
	assign sum = (SUM_W'(in_key[23:20]) + SUM_W'(in_key[19:16])) * SUM_W'(MUL_HUNDREDS)
		+ (SUM_W'(in_key[15:12]) + SUM_W'(in_key[11:8])) * SUM_W'(MUL_TENS)
		+ SUM_W'(in_key[7:4]) + SUM_W'(in_key[3:0]);

	// Reduction by the table size: the quotient comes from a multiply
	// by the scaled reciprocal, the remainder from one subtract.
	assign prod    = PROD_W'(rem_q) * PROD_W'(RECIP_MUL);
	assign quo     = SUM_W'(prod >> RECIP_SHIFT);
	assign reduced = rem_q - quo * SUM_W'(TABLE_SLOTS);

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (in_valid && !hold) begin
					state_d = F_DIV;
				end
			end
			F_DIV: begin
				state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		push     = 1'b0;
		case (state_q)
			F_IDLE:  in_ready = !hold;
			F_PUSH:  push     = !q_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid && !hold) begin
			rem_q     <= sum;
			key_q     <= in_key;
			payload_q <= in_payload;
		end else if (state_q == F_DIV) begin
			rem_q <= reduced;
		end
	end

	assign key     = key_q;
	assign payload = payload_q;
	assign home    = rem_q[SW-1:0];

	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_PUSH |-> rem_q < SUM_W'(TABLE_SLOTS))
		else $error("home slot not reduced below table size");

endmodule

`default_nettype wire

/* design/htpi_queue.sv */
`default_nettype none

module htpi_queue
	import htpi_pkg::*;
#(
	parameter int DATA_W = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   valid,
	output logic [DATA_W-1:0]      pop_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] buf_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     cnt_q;

	assign full     = (cnt_q == CW'(QUEUE_DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> !full) and (pop |-> valid))
		else $error("queue pushed while full or popped while empty");

endmodule

`default_nettype wire

/* design/htpi_back.sv */
`default_nettype none

module htpi_back
	import htpi_pkg::*;
#(
	parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
	parameter int PROBE_STRIDE = PROBE_STRIDE_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	output logic                           clearing,
	input  wire logic                      q_valid,
	output logic                           pop,
	input  wire logic [KEY_W-1:0]          q_key,
	input  wire logic [PAYLOAD_W-1:0]      q_payload,
	input  wire logic [$clog2(TABLE_SLOTS)-1:0] q_home,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [SLOT_W-1:0]              out_slot,
	output logic                           out_evicted,
	output logic [KEY_W-1:0]               out_evicted_key,
	output logic [COUNT_W-1:0]             out_count
);

	localparam int SW   = $clog2(TABLE_SLOTS);
	localparam int STW  = $clog2(TABLE_SLOTS + 1);
	localparam int STEP = PROBE_STRIDE % TABLE_SLOTS;
	localparam logic [SW:0] SLOTS_X = (SW + 1)'(TABLE_SLOTS);

	back_state_t state_q, state_d;

	entry_t mem [TABLE_SLOTS];
	entry_t rd_q;
	entry_t mem_wdata;
	logic   mem_we, mem_re;
	logic [SW-1:0] mem_waddr, mem_raddr;

	logic [SW-1:0]        clr_addr_q;
	logic [SW-1:0]        pos_q, home_q;
	logic [STW-1:0]       steps_q;
	logic                 first_q;
	logic [KEY_W-1:0]     key_q, home_key_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [COUNT_W-1:0]   count_q, count_d;

	logic [SW:0]   pos_sum;
	logic [SW-1:0] next_pos;
	logic          wrap, finish, out_free, adv, cnt_inc, clr_last;
	logic [SW-1:0] wr_slot;

	logic                 out_valid_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 out_evicted_q;
	logic [KEY_W-1:0]     out_evicted_key_q;
	logic [COUNT_W-1:0]   out_count_q;

	assign pos_sum  = {1'b0, pos_q} + (SW + 1)'(STEP);
	assign next_pos = (pos_sum >= SLOTS_X) ? SW'(pos_sum - SLOTS_X) : SW'(pos_sum);
	assign wrap     = (next_pos == home_q) || (steps_q + STW'(1) >= STW'(TABLE_SLOTS));
	assign finish   = (state_q == B_PROBE) && (!rd_q.occ || wrap);
	assign out_free = !out_valid_q || out_ready;
	assign wr_slot  = rd_q.occ ? home_q : pos_q;
	assign clr_last = (clr_addr_q == SW'(TABLE_SLOTS - 1));
	assign cnt_inc  = adv && first_q && rd_q.occ;
	assign count_d  = (cnt_inc && count_q != '1) ? count_q + COUNT_W'(1) : count_q;
	assign clearing = (state_q == B_CLEAR);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_last) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (q_valid) begin
					state_d = B_PROBE;
				end
			end
			B_PROBE: begin
				if (finish && out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		adv       = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = q_home;
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '{occ: 1'b0, key: '0, payload: '0};
		case (state_q)
			B_CLEAR: mem_we = 1'b1;
			B_IDLE: begin
				if (q_valid) begin
					pop    = 1'b1;
					mem_re = 1'b1;
				end
			end
			B_PROBE: begin
				if (!finish || out_free) begin
					adv = 1'b1;
					if (finish) begin
						mem_we    = 1'b1;
						mem_waddr = wr_slot;
						mem_wdata = '{occ: 1'b1, key: key_q, payload: payload_q};
					end else begin
						mem_re    = 1'b1;
						mem_raddr = next_pos;
					end
				end
			end
			default: ;
		endcase
	end

	// Slot memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_addr_q  <= '0;
			count_q     <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == B_CLEAR) begin
				clr_addr_q <= clr_addr_q + SW'(1);
			end
			if (pop) begin
				first_q <= 1'b1;
			end else if (adv) begin
				first_q <= 1'b0;
			end
			if (adv && finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pos_q     <= q_home;
			home_q    <= q_home;
			key_q     <= q_key;
			payload_q <= q_payload;
			steps_q   <= '0;
		end else if (adv && !finish) begin
			pos_q   <= next_pos;
			steps_q <= steps_q + STW'(1);
			if (first_q) begin
				home_key_q <= rd_q.key;
			end
		end
		if (adv && finish) begin
			out_slot_q        <= SLOT_W'(wr_slot);
			out_evicted_q     <= rd_q.occ;
			out_evicted_key_q <= rd_q.occ ? (first_q ? rd_q.key : home_key_q) : '0;
			out_count_q       <= count_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_slot        = out_slot_q;
	assign out_evicted     = out_evicted_q;
	assign out_evicted_key = out_evicted_key_q;
	assign out_count       = out_count_q;

	a_pos_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_PROBE |-> pos_q < SW'(TABLE_SLOTS - 1) || pos_q == SW'(TABLE_SLOTS - 1))
		else $error("probe position outside the table");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && finish) |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");

	a_count_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != B_CLEAR |=> count_q >= $past(count_q))
		else $error("collision count went down");

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_CLEAR |-> !pop)
		else $error("item taken during the clearing pass");

endmodule

`default_nettype wire

/* tb/sv/hash_insert_checker.sv */
`timescale 1ns / 100ps

// Watches both stream channels of the hash insert block, keeps its own copy of
// the occupancy map and stored keys, and compares every result transaction
// against the outcome predicted for the oldest insert still outstanding.

module hash_insert_checker
	import htpi_pkg::*;
#(
	parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
	parameter int PROBE_STRIDE = PROBE_STRIDE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	input  wire logic                         s_tready,
	input  wire logic [KEY_W+PAYLOAD_W-1:0]   s_tdata,
	input  wire logic                         m_tvalid,
	input  wire logic                         m_tready,
	input  wire logic [SLOT_W+KEY_W+COUNT_W-1:0] m_tdata,
	input  wire logic [0:0]                   m_tuser,
	output int unsigned                       outstanding,
	output int unsigned                       mismatches,
	output int unsigned                       results_seen,
	output int unsigned                       evictions_seen
);

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic               evicted;
		logic [KEY_W-1:0]   evicted_key;
		logic [COUNT_W-1:0] collisions;
	} insert_outcome_t;

	bit                 occupied [TABLE_SLOTS];
	logic [KEY_W-1:0]   stored_key [TABLE_SLOTS];
	logic [COUNT_W-1:0] collision_total;
	insert_outcome_t    pending_outcomes [$];

	function automatic int unsigned home_of(logic [KEY_W-1:0] key);
		int unsigned digit_sum;
		digit_sum = (key[23:20] + key[19:16]) * 100
			+ (key[15:12] + key[11:8]) * 10
			+ key[7:4] + key[3:0];
		return digit_sum % TABLE_SLOTS;
	endfunction

	// Places one key in the shadow table and returns what the block must report.
	function automatic insert_outcome_t place_entry(logic [KEY_W-1:0] key);
		insert_outcome_t res;
		int unsigned     home;
		int unsigned     spot;
		int unsigned     hops;
		res  = '0;
		home = home_of(key);
		spot = home;
		if (occupied[home]) begin
			if (collision_total != '1)
				collision_total++;
			hops = 0;
			while (occupied[spot]) begin
				spot = (spot + PROBE_STRIDE) % TABLE_SLOTS;
				hops++;
				if (spot == home || hops >= TABLE_SLOTS) begin
					spot            = home;
					res.evicted     = 1'b1;
					res.evicted_key = stored_key[home];
					break;
				end
			end
		end
		occupied[spot]   = 1'b1;
		stored_key[spot] = key;
		res.slot         = spot[SLOT_W-1:0];
		res.collisions   = collision_total;
		return res;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		insert_outcome_t want;
		if (!arst_n) begin
			foreach (occupied[i])
				occupied[i] = 1'b0;
			collision_total = '0;
			pending_outcomes.delete();
			mismatches     = 0;
			results_seen   = 0;
			evictions_seen = 0;
			outstanding <= 0;
		end else begin
			// Results are checked before new inserts are queued, so a result can never
			// be matched against the insert accepted at the same edge.
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_outcomes.size() == 0) begin
					$error("result transaction with no insert outstanding: m_tdata %0h", m_tdata);
					mismatches++;
				end else begin
					want = pending_outcomes.pop_front();
					if (want.evicted)
						evictions_seen++;
					check_field("slot_used", 64'(want.slot), 64'(m_tdata[SLOT_W-1:0]));
					check_field("evicted", 64'(want.evicted), 64'(m_tuser[0]));
					check_field("evicted_key", 64'(want.evicted_key),
						64'(m_tdata[SLOT_W +: KEY_W]));
					check_field("collision_count", 64'(want.collisions),
						64'(m_tdata[SLOT_W+KEY_W +: COUNT_W]));
				end
			end
			if (s_tvalid && s_tready)
				pending_outcomes.push_back(place_entry(s_tdata[KEY_W-1:0]));
			outstanding <= pending_outcomes.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

// Top of the hash insert testbench. It drives insert transactions into the block,
// applies random backpressure on the result channel and gives the verdict. All
// prediction and comparison lives in the checker instance beside the block.

module tb;
	import htpi_pkg::*;

	localparam int SLOTS  = TABLE_SLOTS_DEF;
	localparam int STRIDE = PROBE_STRIDE_DEF;

	// Random inserts after the directed opening.
	localparam int RANDOM_INSERTS = 930;
	// Within this window of random inserts neither side idles.
	localparam int QUIET_FIRST = 350;
	localparam int QUIET_LAST  = 549;
	// Percentage of cycles in which a side idles outside the quiet window.
	localparam int IDLE_PCT = 16;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [KEY_W+PAYLOAD_W-1:0]         s_tdata;   // key_bcd[23:0], payload[55:24]
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	logic [SLOT_W+KEY_W+COUNT_W-1:0]    m_tdata;   // slot_used[7:0], evicted_key[31:8],
	                                               // collision_count[63:32]
	logic [0:0]                         m_tuser;   // evicted[0]
	logic                               quiet = 1'b0;
	int unsigned                        outstanding;
	int unsigned                        mismatches;
	int unsigned                        results_seen;
	int unsigned                        evictions_seen;

	// Every key sent so far; replaying one forces a hit on an occupied home slot.
	logic [KEY_W-1:0]                   sent_keys [$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	hash_table_probe_insert #(
		.TABLE_SLOTS  (SLOTS),
		.PROBE_STRIDE (STRIDE)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	hash_insert_checker #(
		.TABLE_SLOTS  (SLOTS),
		.PROBE_STRIDE (STRIDE)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.outstanding    (outstanding),
		.mismatches     (mismatches),
		.results_seen   (results_seen),
		.evictions_seen (evictions_seen)
	);

	// The result side stalls at random, except inside the quiet window. It stays
	// low during reset so nothing is taken before the block is running.
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	// Offers one insert transaction and returns at the edge where it is taken.
	// The valid line is left high afterwards; the next call either drops it for an
	// idle cycle or presents new data, so it is only ever assigned once per edge.
	task automatic send_entry(input logic [KEY_W-1:0] key, input logic [PAYLOAD_W-1:0] data);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {data, key};
		sent_keys.push_back(key);
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Mostly well-formed BCD keys, some keys with arbitrary nibbles, and some
	// replays of earlier keys so that chains on one home slot grow long.
	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] key;
		int unsigned      mode;
		mode = $urandom_range(9);
		if (mode < 6 || sent_keys.size() == 0) begin
			for (int d = 0; d < KEY_W / DIGIT_W; d++)
				key[DIGIT_W*d +: DIGIT_W] = DIGIT_W'($urandom_range(9));
		end else if (mode < 8) begin
			key = KEY_W'($urandom);
		end else begin
			key = sent_keys[$urandom_range(sent_keys.size() - 1)];
		end
		return key;
	endfunction

	function automatic logic [PAYLOAD_W-1:0] pick_payload();
		int unsigned mode;
		mode = $urandom_range(9);
		if (mode == 0)
			return '0;
		else if (mode == 1)
			return '1;
		return $urandom;
	endfunction

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening. The block holds s_tready low while it clears the slot
		// memory, so the first transaction simply waits for that pass to finish.
		send_entry(24'h000000, 32'h0000_0000);   // home slot 0, empty table
		send_entry(24'h000000, 32'hFFFF_FFFF);   // same home: first collision, one probe
		send_entry(24'h000000, 32'h8000_0001);   // chain grows to a second probe
		send_entry(24'h000007, 32'h0000_0001);   // home 7 is taken by the probe above
		send_entry(24'hFFFFFF, 32'hA5A5_A5A5);   // all nibbles non-BCD, largest digit sum
		send_entry(24'h999999, 32'h5A5A_5A5A);   // largest well-formed key
		send_entry(24'h999999, 32'h1234_5678);   // replay of it collides
		send_entry(24'h100000, 32'h0000_FFFF);   // weight of the hundreds pair
		send_entry(24'h010000, 32'hFFFF_0000);   // same sum, other digit of the pair
		send_entry(24'h001000, 32'h0F0F_0F0F);
		send_entry(24'h000100, 32'hF0F0_F0F0);
		send_entry(24'h000010, 32'h3333_3333);
		send_entry(24'h000001, 32'hCCCC_CCCC);
		send_entry(24'hA00000, 32'h0000_0002);   // one non-BCD nibble in each position
		send_entry(24'h0B0000, 32'h0000_0004);
		send_entry(24'h00C000, 32'h0000_0008);
		send_entry(24'h000D00, 32'h0000_0010);
		send_entry(24'h0000E0, 32'h0000_0020);
		send_entry(24'h00000F, 32'h0000_0040);
		send_entry(24'h123456, 32'h5555_5555);
		send_entry(24'h654321, 32'hAAAA_AAAA);
		send_entry(24'h555555, 32'h7FFF_FFFF);

		// Random part. The table fills after a few hundred inserts; from then on
		// every insert walks the whole table and evicts its home entry.
		for (int n = 0; n < RANDOM_INSERTS; n++) begin
			if (n == QUIET_FIRST)
				quiet <= 1'b1;
			else if (n == QUIET_LAST + 1)
				quiet <= 1'b0;
			send_entry(pick_key(), pick_payload());
		end
		s_tvalid <= 1'b0;

		// Drain, then leave room for one more full walk so a stray result shows up.
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SLOTS + 16) @(posedge clk);

		$display("Sent %0d insert transactions; %0d results checked, %0d of them evictions.",
			sent_keys.size(), results_seen, evictions_seen);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog: a correct run needs a few milliseconds at most, even when every
	// insert walks the full table behind random stalls.
	initial begin
		#30_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

/* hash_table_probe_insert.f */
design/htpi_pkg.sv
design/htpi_front.sv
design/htpi_queue.sv
design/htpi_back.sv
design/hash_table_probe_insert.sv
tb/sv/hash_insert_checker.sv
tb/sv/tb.sv
